@@ rtl/tty_output_processing_defines.svh @@
// Assertion macros shared by the terminal output processing checker
`ifndef TTY_OUTPUT_PROCESSING_DEFINES_SVH
`define TTY_OUTPUT_PROCESSING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TTY_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tty output processing check failed");

// Next-cycle implication, sampled on clk, off during reset
`define TTY_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tty output processing check failed");

`endif

@@ rtl/tty_op_pkg.sv @@
// Types and constants for terminal output processing
package tty_op_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ECHO   = 2'd1,
    CMD_RUBOUT = 2'd2
  } cmd_t;

  localparam logic [2:0] REG_CANONICAL   = 3'd0;
  localparam logic [2:0] REG_EXPAND_TABS = 3'd1;
  localparam logic [2:0] REG_MAP_CRLF    = 3'd2;
  localparam logic [2:0] REG_ECHO        = 3'd3;
  localparam logic [2:0] REG_ERASE_VIS   = 3'd4;
  localparam logic [2:0] REG_ECHO_NL     = 3'd5;
  localparam logic [2:0] REG_ERASE_CHAR  = 3'd6;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CTRL_SHOW = 8'h40;

  typedef struct packed {
    logic       canonical;
    logic       expand_tabs;
    logic       map_crlf;
    logic       echo_en;
    logic       erase_visual;
    logic       echo_nl;
    logic [7:0] erase_char;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    canonical:    1'b1,
    expand_tabs:  1'b0,
    map_crlf:     1'b1,
    echo_en:      1'b1,
    erase_visual: 1'b1,
    echo_nl:      1'b0,
    erase_char:   CH_DEL
  };

endpackage

@@ rtl/tty_output_processing.sv @@
// Terminal output processing top level: tab, newline, echo and rubout handling
//
// Each accepted transaction carries a command (write, echo, rubout) and a
// character. It is registered, turned combinationally into up to eight
// output bytes with the updated cursor column, and those bytes leave one per
// cycle, while out_tready is high, on the result channel, the final byte of
// each input marked by out_tlast. The input waits in the input register
// until the output buffer is free; then its bytes are loaded into the buffer
// and the first byte shows on the result channel. An input yields zero to
// eight bytes, eight for a fully expanded tab. The one-byte result channel
// sets the sustained rate, and the next input is taken while the current
// bytes are still draining.
module tty_output_processing #(
  parameter int COLUMN_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic [1:0] in_tuser,   // [1:0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import tty_op_pkg::*;

  typedef struct packed {
    logic [63:0]             bytes;
    logic [3:0]              n;
    logic [COLUMN_WIDTH-1:0] col;
  } put_res_t;

  function automatic put_res_t put_byte(cfg_t cfg, logic [COLUMN_WIDTH-1:0] col,
                                        logic [7:0] c);
    put_res_t r;
    r.bytes = '0;
    r.n     = 4'd1;
    r.col   = col;
    r.bytes[7:0] = c;
    if (cfg.canonical) begin
      if (c == CH_TAB && cfg.expand_tabs) begin
        r.n     = 4'd8 - {1'b0, col[2:0]};
        r.bytes = {8{CH_SPACE}};
        r.col   = col + COLUMN_WIDTH'(r.n);
      end else begin
        if (c == CH_LF && cfg.map_crlf) begin
          r.bytes[15:0] = {c, CH_CR};
          r.n           = 4'd2;
        end
        if (c == CH_BS) begin
          if (col != '0) begin
            r.col = col - 1'b1;
          end
        end else if (c == CH_TAB) begin
          r.col = {col[COLUMN_WIDTH-1:3] + 1'b1, 3'b000};
        end else if (c == CH_LF || c == CH_CR) begin
          r.col = '0;
        end else if (!(c < CH_SPACE || c == CH_DEL)) begin
          r.col = col + 1'b1;
        end
      end
    end
    return r;
  endfunction

  cfg_t                    cfg_r;
  logic [COLUMN_WIDTH-1:0] col_r;
  logic                    in_vld_r;
  cmd_t                    in_cmd_r;
  logic [7:0]              in_char_r;
  logic                    buf_vld_r;
  logic [63:0]             buf_r;
  logic [2:0]              buf_idx_r;
  logic [2:0]              buf_last_r;

  logic                    buf_free;
  logic                    xfer;
  logic                    in_acc;
  logic [7:0]              p0, p1, p2;
  logic [1:0]              np;
  put_res_t                r0, r1, r2;
  logic [63:0]             bytes_nxt;
  logic [3:0]              cnt_nxt;
  logic [COLUMN_WIDTH-1:0] col_nxt;

  assign buf_free  = !buf_vld_r || (out_tready && buf_idx_r == buf_last_r);
  assign xfer      = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || buf_free;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = buf_vld_r;
  assign out_tdata  = buf_r[{buf_idx_r, 3'b000} +: 8];
  assign out_tlast  = buf_idx_r == buf_last_r;

  // decode command into up to three characters for output processing
  always_comb begin
    p0 = in_char_r;
    p1 = CH_SPACE;
    p2 = CH_BS;
    np = 2'd0;
    case (in_cmd_r)
      CMD_WRITE: begin
        np = 2'd1;
      end
      CMD_ECHO: begin
        if (!cfg_r.echo_en) begin
          p0 = CH_LF;
          np = (in_char_r == CH_LF && cfg_r.echo_nl) ? 2'd1 : 2'd0;
        end else if ((in_char_r < CH_SPACE || in_char_r == CH_DEL) &&
                     in_char_r != CH_LF && in_char_r != CH_TAB &&
                     in_char_r != CH_BS) begin
          p0 = CH_CARET;
          p1 = in_char_r + CTRL_SHOW;
          np = 2'd2;
        end else begin
          np = 2'd1;
        end
      end
      CMD_RUBOUT: begin
        if (!cfg_r.echo_en) begin
          np = 2'd0;
        end else if (cfg_r.erase_visual) begin
          p0 = CH_BS;
          np = 2'd3;
        end else begin
          p0 = cfg_r.erase_char;
          np = 2'd1;
        end
      end
      default: begin
        np = 2'd0;
      end
    endcase
  end

  // chain the characters through the column and pack the bytes in order
  always_comb begin
    r0 = put_byte(cfg_r, col_r, p0);
    r1 = put_byte(cfg_r, r0.col, p1);
    r2 = put_byte(cfg_r, r1.col, p2);
    bytes_nxt = '0;
    cnt_nxt   = 4'd0;
    col_nxt   = col_r;
    if (np >= 2'd1) begin
      bytes_nxt = r0.bytes;
      cnt_nxt   = r0.n;
      col_nxt   = r0.col;
    end
    if (np >= 2'd2) begin
      bytes_nxt = bytes_nxt | (r1.bytes << {r0.n, 3'b000});
      cnt_nxt   = cnt_nxt + r1.n;
      col_nxt   = r1.col;
    end
    if (np == 2'd3) begin
      bytes_nxt = bytes_nxt | (r2.bytes << {cnt_nxt, 3'b000});
      cnt_nxt   = cnt_nxt + r2.n;
      col_nxt   = r2.col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= CFG_RESET;
      col_r      <= '0;
      in_vld_r   <= 1'b0;
      buf_vld_r  <= 1'b0;
      buf_idx_r  <= '0;
      buf_last_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_CANONICAL:   cfg_r.canonical    <= cfg_data[0];
          REG_EXPAND_TABS: cfg_r.expand_tabs  <= cfg_data[0];
          REG_MAP_CRLF:    cfg_r.map_crlf     <= cfg_data[0];
          REG_ECHO:        cfg_r.echo_en      <= cfg_data[0];
          REG_ERASE_VIS:   cfg_r.erase_visual <= cfg_data[0];
          REG_ECHO_NL:     cfg_r.echo_nl      <= cfg_data[0];
          REG_ERASE_CHAR:  cfg_r.erase_char   <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (xfer) begin
        in_vld_r <= 1'b0;
      end
      if (xfer) begin
        col_r <= col_nxt;
      end
      if (xfer && cnt_nxt != 4'd0) begin
        buf_vld_r  <= 1'b1;
        buf_idx_r  <= '0;
        buf_last_r <= 3'(cnt_nxt - 4'd1);
      end else if (buf_vld_r && out_tready) begin
        if (buf_idx_r == buf_last_r) begin
          buf_vld_r <= 1'b0;
        end else begin
          buf_idx_r <= buf_idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cmd_r  <= cmd_t'(in_tuser);
      in_char_r <= in_tdata;
    end
    if (xfer && cnt_nxt != 4'd0) begin
      buf_r <= bytes_nxt;
    end
  end

endmodule

@@ rtl/tty_op_checker.sv @@
// Port-level checker for terminal output processing, bound to the top level
`include "tty_output_processing_defines.svh"

module tty_op_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `TTY_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  `TTY_ASSERT_IMP(a_ready_when_drained, !out_tvalid, in_tready)

  `TTY_ASSERT_IMP(a_reset_empty, $past(!rst_n), !out_tvalid && in_tready)

endmodule

bind tty_output_processing tty_op_checker u_tty_op_checker (.*);

@@ tb/tb.sv @@
// Testbench for tty_output_processing: directed table, then random phases against a line model
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tty_op_pkg::*;

  localparam int         COL_W      = 16;
  localparam int         PAD_CYCLES = 8;
  localparam int         HOLD_SPAN  = 100;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] REG_NONE   = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_byte_t;

  typedef struct packed {
    logic        is_reg;
    logic [2:0]  idx;
    logic [7:0]  val;
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic        typed;
    logic [3:0]  n_bytes;
    logic [63:0] bytes;
  } step_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic [1:0] in_tuser   = 2'd0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_wr_en  = 1'b0;
  logic [2:0] cfg_index  = 3'd0;
  logic [7:0] cfg_data   = 8'h00;

  cfg_t             line_cfg   = CFG_RESET;
  logic [COL_W-1:0] cursor_col = '0;
  logic [7:0]       item_bytes [$];
  line_byte_t       line_expect [$];
  int               errors     = 0;
  bit               hold_req   = 1'b0;
  step_t            plan [$];

  tty_output_processing #(.COLUMN_WIDTH(COL_W)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tty_output_processing: mismatch");
    $finish;
  end

  // Line model
  function automatic void put_line_byte(logic [7:0] c);
    int n;
    if (!line_cfg.canonical) begin
      item_bytes.push_back(c);
      return;
    end
    if (c == CH_TAB && line_cfg.expand_tabs) begin
      n = 8 - int'(cursor_col[2:0]);
      cursor_col = cursor_col + COL_W'(n);
      repeat (n) item_bytes.push_back(CH_SPACE);
      return;
    end
    if (c == CH_LF && line_cfg.map_crlf) item_bytes.push_back(CH_CR);
    item_bytes.push_back(c);
    if (c == CH_BS) begin
      if (cursor_col != '0) cursor_col = cursor_col - 1'b1;
    end else if (c == CH_TAB) begin
      cursor_col = (cursor_col + COL_W'(8)) & ~COL_W'(7);
    end else if (c == CH_LF || c == CH_CR) begin
      cursor_col = '0;
    end else if (!(c < CH_SPACE || c == CH_DEL)) begin
      cursor_col = cursor_col + 1'b1;
    end
  endfunction

  function automatic void model_line_item(logic [1:0] cmd, logic [7:0] c);
    item_bytes.delete();
    if (cmd == CMD_WRITE) begin
      put_line_byte(c);
    end else if (cmd == CMD_ECHO) begin
      if (!line_cfg.echo_en) begin
        if (c == CH_LF && line_cfg.echo_nl) put_line_byte(CH_LF);
      end else if ((c < CH_SPACE || c == CH_DEL) && c != CH_LF && c != CH_TAB && c != CH_BS) begin
        put_line_byte(CH_CARET);
        put_line_byte(8'(c + CTRL_SHOW));
      end else begin
        put_line_byte(c);
      end
    end else if (cmd == CMD_RUBOUT && line_cfg.echo_en) begin
      if (line_cfg.erase_visual) begin
        put_line_byte(CH_BS);
        put_line_byte(CH_SPACE);
        put_line_byte(CH_BS);
      end else begin
        put_line_byte(line_cfg.erase_char);
      end
    end
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [7:0] val);
    case (idx)
      REG_CANONICAL:   line_cfg.canonical    = val[0];
      REG_EXPAND_TABS: line_cfg.expand_tabs  = val[0];
      REG_MAP_CRLF:    line_cfg.map_crlf     = val[0];
      REG_ECHO:        line_cfg.echo_en      = val[0];
      REG_ERASE_VIS:   line_cfg.erase_visual = val[0];
      REG_ECHO_NL:     line_cfg.echo_nl      = val[0];
      REG_ERASE_CHAR:  line_cfg.erase_char   = val;
      default: ;
    endcase
  endfunction

  function automatic step_t reg_row(logic [2:0] idx, logic [7:0] val);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic step_t item_row(logic [1:0] cmd, logic [7:0] ch);
    step_t s;
    s = '0;
    s.cmd = cmd;
    s.ch = ch;
    return s;
  endfunction

  function automatic step_t typed_row(logic [1:0] cmd, logic [7:0] ch, logic [3:0] n,
                                      logic [63:0] bytes);
    step_t s;
    s = item_row(cmd, ch);
    s.typed = 1'b1;
    s.n_bytes = n;
    s.bytes = bytes;
    return s;
  endfunction

  function automatic logic [7:0] pick_char();
    logic [7:0] specials [8];
    specials = '{CH_TAB, CH_LF, CH_CR, CH_BS, CH_DEL, 8'h00, 8'hFF, 8'h1B};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(32, 126));
      4, 5:       return specials[$urandom_range(0, 7)];
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return CMD_WRITE;
    if (r < 15) return CMD_ECHO;
    if (r < 19) return CMD_RUBOUT;
    return CMD_UNUSED;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: %s: got %02h want %02h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic typed = 1'b0,
                           logic [3:0] n = '0, logic [63:0] bytes = '0);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_line_item(cmd, ch);
    if (typed) begin
      item_bytes.delete();
      for (int i = 0; i < n; i++) item_bytes.push_back(bytes[8*i +: 8]);
    end
    for (int i = 0; i < item_bytes.size(); i++)
      line_expect.push_back('{ch: item_bytes[i], last: (i == item_bytes.size() - 1)});
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle_line();
    in_tvalid <= 1'b0;
    while (line_expect.size() != 0) @(posedge clk);
    repeat (PAD_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(logic [2:0] idx, logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_setting(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_phase(int phase);
    logic [5:0] bits;
    logic [7:0] erase;
    logic [7:0] erase_pick [6];
    erase_pick = '{CH_TAB, CH_LF, CH_BS, CH_DEL, CH_CR, 8'($urandom_range(0, 255))};
    if (phase == 0) begin
      bits  = 6'b111111;
      erase = 8'hFF;
    end else if (phase == 1) begin
      bits  = 6'b000000;
      erase = 8'h00;
    end else begin
      bits    = 6'($urandom);
      bits[0] = ($urandom_range(0, 3) != 0);
      bits[3] = ($urandom_range(0, 3) != 0);
      erase   = erase_pick[$urandom_range(0, 5)];
    end
    write_setting(REG_CANONICAL,   {7'($urandom), bits[0]});
    write_setting(REG_EXPAND_TABS, {7'($urandom), bits[1]});
    write_setting(REG_MAP_CRLF,    {7'($urandom), bits[2]});
    write_setting(REG_ECHO,        {7'($urandom), bits[3]});
    write_setting(REG_ERASE_VIS,   {7'($urandom), bits[4]});
    write_setting(REG_ECHO_NL,     {7'($urandom), bits[5]});
    write_setting(REG_ERASE_CHAR,  erase);
  endtask

  // Result receiver
  initial begin
    int span;
    int mode;
    int tick;
    tick = 0;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_SPAN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 40);
        repeat (span) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 2) != 0);
            2:       out_tready <= (tick % 3 == 0);
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    line_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_expect.size() == 0) begin
        report_mismatch("unexpected output transaction", out_tdata, 8'h00);
      end else begin
        want = line_expect.pop_front();
        if (out_tdata !== want.ch) report_mismatch("out_tdata", out_tdata, want.ch);
        if (out_tlast !== want.last)
          report_mismatch("out_tlast", {7'd0, out_tlast}, {7'd0, want.last});
      end
    end
  end

  initial begin
    int burst_left;
    burst_left = 0;
    plan = '{
      typed_row(CMD_WRITE,  8'h41,  1, 64'h41),
      typed_row(CMD_WRITE,  8'hFF,  1, 64'hFF),
      typed_row(CMD_WRITE,  8'h00,  1, 64'h00),
      typed_row(CMD_WRITE,  CH_LF,  2, 64'h0A0D),
      typed_row(CMD_ECHO,   8'h01,  2, 64'h415E),
      typed_row(CMD_ECHO,   CH_DEL, 2, 64'hBF5E),
      typed_row(CMD_RUBOUT, 8'hAA,  3, 64'h082008),
      typed_row(CMD_UNUSED, 8'hFF,  0, 64'h0),
      item_row(CMD_ECHO, CH_TAB),
      item_row(CMD_WRITE, CH_BS),
      typed_row(CMD_ECHO,   CH_LF,  2, 64'h0A0D),
      typed_row(CMD_WRITE,  CH_CR,  1, 64'h0D),
      reg_row(REG_NONE, 8'h00),
      reg_row(REG_EXPAND_TABS, 8'hA5),
      typed_row(CMD_WRITE,  CH_TAB, 8, 64'h2020202020202020),
      item_row(CMD_WRITE, 8'h7E),
      item_row(CMD_WRITE, CH_TAB),
      reg_row(REG_ECHO, 8'hFE),
      typed_row(CMD_ECHO,   CH_LF,  0, 64'h0),
      typed_row(CMD_RUBOUT, 8'h00,  0, 64'h0),
      reg_row(REG_ECHO_NL, 8'h01),
      typed_row(CMD_ECHO,   CH_LF,  2, 64'h0A0D),
      typed_row(CMD_ECHO,   8'h61,  0, 64'h0),
      reg_row(REG_ECHO, 8'h01),
      reg_row(REG_ERASE_VIS, 8'h00),
      reg_row(REG_ERASE_CHAR, CH_TAB),
      item_row(CMD_RUBOUT, 8'h55),
      reg_row(REG_ERASE_CHAR, 8'hFF),
      typed_row(CMD_RUBOUT, 8'h00,  1, 64'hFF),
      reg_row(REG_MAP_CRLF, 8'h00),
      typed_row(CMD_WRITE,  CH_LF,  1, 64'h0A),
      reg_row(REG_CANONICAL, 8'h00),
      typed_row(CMD_WRITE,  CH_TAB, 1, 64'h09),
      typed_row(CMD_ECHO,   8'h1B,  2, 64'h5B5E),
      typed_row(CMD_ECHO,   8'h00,  2, 64'h405E),
      item_row(CMD_WRITE, CH_BS)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle_line();
        write_setting(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].cmd, plan[i].ch, plan[i].typed, plan[i].n_bytes, plan[i].bytes);
        if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      settle_line();
      program_phase(phase);
      if (phase == 2) hold_req = 1'b1;
      for (int k = 0; k < 48; k++) begin
        if (k == 24) begin
          settle_line();
        end else if (burst_left == 0) begin
          idle_gap($urandom_range(1, 8));
          burst_left = $urandom_range(1, 16);
        end
        send_item(pick_cmd(), pick_char());
        if (burst_left > 0) burst_left--;
      end
    end

    settle_line();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tty_output_processing: match");
    end else begin
      $display("tty_output_processing: mismatch");
    end
    $finish;
  end

endmodule
